// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define TPLS_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define TPLS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/tpls_pkg.sv =====
// Types, codes and phase table of the printhead line sequencer.
`default_nettype none

package tpls_pkg;

	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_MOTOR = 2'd1,
		KIND_HEAT  = 2'd2,
		KIND_PAPER = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CAUSE_NONE  = 2'd0,
		CAUSE_DONE  = 2'd1,
		CAUSE_PAPER = 2'd2,
		CAUSE_POWER = 2'd3
	} cause_t;

	typedef enum logic [2:0] {
		POS_IDLE      = 3'b001,
		POS_WAIT_HEAT = 3'b010,
		POS_WAIT_LINE = 3'b100
	} pos_t;

	typedef enum logic [2:0] {
		HS_IDLE   = 3'b001,
		HS_FIRST  = 3'b010,
		HS_SECOND = 3'b100
	} heat_t;

	localparam logic [3:0] COIL_A_POS = 4'b1000;
	localparam logic [3:0] COIL_A_NEG = 4'b0100;
	localparam logic [3:0] COIL_B_POS = 4'b0010;
	localparam logic [3:0] COIL_B_NEG = 4'b0001;

	localparam logic [3:0] PHASE_COUNT = 4'd8;
	localparam logic [3:0] STEP_LINE_A = 4'd5;
	localparam logic [3:0] STEP_LINE_B = 4'd9;

	localparam logic [1:0] STROBE_OFF    = 2'b00;
	localparam logic [1:0] STROBE_FIRST  = 2'b01;
	localparam logic [1:0] STROBE_SECOND = 2'b10;

	typedef struct packed {
		logic [3:0] motor_pins;
		logic       strobe_first;
		logic       strobe_second;
		logic       latch_line;
		logic       motor_running;
		logic       heat_running;
		logic       busy_res;
		cause_t     end_cause;
	} res_t;

	// forward half-step phase table, indexed by step 1..8
	function automatic logic [3:0] phase_pins(input logic [3:0] step);
		logic [3:0] pins;
		case (step)
			4'd1:    pins = COIL_A_POS | COIL_B_NEG;
			4'd2:    pins = COIL_A_POS | COIL_A_NEG | COIL_B_NEG;
			4'd3:    pins = COIL_A_NEG | COIL_B_NEG;
			4'd4:    pins = COIL_A_NEG | COIL_B_POS | COIL_B_NEG;
			4'd5:    pins = COIL_A_NEG | COIL_B_POS;
			4'd6:    pins = COIL_A_POS | COIL_A_NEG | COIL_B_POS;
			4'd7:    pins = COIL_A_POS | COIL_B_POS;
			4'd8:    pins = COIL_A_POS | COIL_B_POS | COIL_B_NEG;
			default: pins = COIL_A_POS | COIL_B_NEG;
		endcase
		return pins;
	endfunction

	// out-of-range step folds back to the first phase
	function automatic logic [3:0] fix_step(input logic [3:0] step);
		return (step inside {[4'd1:PHASE_COUNT]}) ? step : 4'd1;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/thermal_printhead_line_sequencer_core.sv =====
// Printhead line sequencer: job control, motor half-stepping and strobe sequencing.
//
//   channel | signals                                       | dir
//   --------+-----------------------------------------------+----
//   in      | in_valid in_stall kind line_count supply_lost | in
//   out     | out_valid out_stall motor_pins strobe_first   | out
//           | strobe_second latch_line motor_running        |
//           | heat_running busy_res end_cause               |
//
// One request per cycle while in_stall is low; a request is held in the request register,
// and its result is then registered in the result register or the skid register.
// Reset returns all job state to its idle values; no job is running and the motor is stopped.
// A stalled result is held while the next one lands in a skid register;
// in_stall rises only while the skid register is full.
`default_nettype none
`include "assert_macros.svh"

module thermal_printhead_line_sequencer_core #(
	parameter int LINE_COUNT_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [15:0] line_count,
	input  wire logic        supply_lost,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [3:0]  motor_pins,
	output      logic        strobe_first,
	output      logic        strobe_second,
	output      logic        latch_line,
	output      logic        motor_running,
	output      logic        heat_running,
	output      logic        busy_res,
	output      logic [1:0]  end_cause
);

	typedef logic [LINE_COUNT_BITS-1:0] lines_t;

	// request register
	logic                valid_s1;
	tpls_pkg::kind_t     kind_s1;
	logic [15:0]         count_s1;
	logic                power_s1;

	// job state
	tpls_pkg::pos_t      pos_q,    pos_d;
	tpls_pkg::heat_t     stage_q,  stage_d;
	logic [3:0]          step_q,   step_d;
	logic                ld_q,     ld_d;
	logic                first_q,  first_d;
	logic                stop_q,   stop_d;
	logic                paper_q,  paper_d;
	lines_t              lines_q,  lines_d;
	logic [3:0]          pins_q,   pins_d;
	logic                men_q,    men_d;
	logic                hen_q,    hen_d;
	logic [1:0]          strobe_q, strobe_d;
	logic                latch_d;
	tpls_pkg::cause_t    cause_d;

	// result buffer
	logic                out_valid_q, skid_valid_q;
	tpls_pkg::res_t      out_q, skid_q, res_d;
	logic                fire, out_take, s1_load;

	assign in_stall = valid_s1 && skid_valid_q;
	assign s1_load  = in_valid && !in_stall;
	assign fire     = valid_s1 && !skid_valid_q;
	assign out_take = out_valid_q && !out_stall;

	always_comb begin
		pos_d    = pos_q;
		stage_d  = stage_q;
		step_d   = step_q;
		ld_d     = ld_q;
		first_d  = first_q;
		stop_d   = stop_q;
		paper_d  = paper_q;
		lines_d  = lines_q;
		pins_d   = pins_q;
		men_d    = men_q;
		hen_d    = hen_q;
		strobe_d = strobe_q;
		latch_d  = 1'b0;
		cause_d  = tpls_pkg::CAUSE_NONE;

		case (kind_s1)
			tpls_pkg::KIND_START: begin
				if (pos_q == tpls_pkg::POS_IDLE) begin
					lines_d  = LINE_COUNT_BITS'(count_s1);
					ld_d     = 1'b1;
					first_d  = 1'b1;
					stop_d   = 1'b0;
					step_d   = 4'd1;
					strobe_d = tpls_pkg::STROBE_OFF;
					pos_d    = tpls_pkg::POS_WAIT_HEAT;
				end
			end
			tpls_pkg::KIND_MOTOR: begin
				if (men_q) begin
					step_d = step_q + 4'd1;
					if (step_d inside {tpls_pkg::STEP_LINE_A, tpls_pkg::STEP_LINE_B})
						ld_d = 1'b1;
					if (stop_d && ld_d) begin
						men_d  = 1'b0;
						pins_d = 4'd0;
					end else begin
						step_d = tpls_pkg::fix_step(step_d);
						pins_d = tpls_pkg::phase_pins(step_d);
					end
				end
			end
			tpls_pkg::KIND_HEAT: begin
				if (hen_q) begin
					case (stage_q)
						tpls_pkg::HS_FIRST: begin
							strobe_d = tpls_pkg::STROBE_SECOND;
							stage_d  = tpls_pkg::HS_SECOND;
						end
						tpls_pkg::HS_SECOND: begin
							strobe_d = tpls_pkg::STROBE_OFF;
							stage_d  = tpls_pkg::HS_IDLE;
							hen_d    = 1'b0;
						end
						default: ;
					endcase
				end
			end
			tpls_pkg::KIND_PAPER: begin
				paper_d = 1'b1;
			end
			default: ;
		endcase

		// line boundary handling
		if (pos_d == tpls_pkg::POS_WAIT_HEAT && stage_d == tpls_pkg::HS_IDLE) begin
			if (lines_d != '0) begin
				latch_d = 1'b1;
				lines_d = lines_d - LINE_COUNT_BITS'(1);
			end else begin
				stop_d = 1'b1;
			end
			if (first_d) begin
				first_d = 1'b0;
				step_d  = tpls_pkg::fix_step(step_d);
				pins_d  = tpls_pkg::phase_pins(step_d);
				men_d   = 1'b1;
			end
			pos_d = tpls_pkg::POS_WAIT_LINE;
		end
		if (pos_d == tpls_pkg::POS_WAIT_LINE && ld_d) begin
			ld_d = 1'b0;
			if (stop_d || paper_d || power_s1) begin
				if (stop_d)
					cause_d = tpls_pkg::CAUSE_DONE;
				else if (paper_d)
					cause_d = tpls_pkg::CAUSE_PAPER;
				else
					cause_d = tpls_pkg::CAUSE_POWER;
				step_d   = 4'd0;
				stop_d   = 1'b1;
				hen_d    = 1'b0;
				strobe_d = tpls_pkg::STROBE_OFF;
				pos_d    = tpls_pkg::POS_IDLE;
			end else begin
				stage_d  = tpls_pkg::HS_FIRST;
				strobe_d = tpls_pkg::STROBE_FIRST;
				hen_d    = 1'b1;
				pos_d    = tpls_pkg::POS_WAIT_HEAT;
			end
		end

		res_d.motor_pins    = pins_d;
		res_d.strobe_first  = strobe_d[0];
		res_d.strobe_second = strobe_d[1];
		res_d.latch_line    = latch_d;
		res_d.motor_running = men_d;
		res_d.heat_running  = hen_d;
		res_d.busy_res      = (pos_d != tpls_pkg::POS_IDLE);
		res_d.end_cause     = cause_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_load) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			kind_s1  <= tpls_pkg::kind_t'(kind);
			count_s1 <= line_count;
			power_s1 <= supply_lost;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= tpls_pkg::POS_IDLE;
			stage_q  <= tpls_pkg::HS_IDLE;
			step_q   <= 4'd0;
			ld_q     <= 1'b1;
			first_q  <= 1'b1;
			stop_q   <= 1'b1;
			paper_q  <= 1'b0;
			lines_q  <= '0;
			pins_q   <= 4'd0;
			men_q    <= 1'b0;
			hen_q    <= 1'b0;
			strobe_q <= tpls_pkg::STROBE_OFF;
		end else if (fire) begin
			pos_q    <= pos_d;
			stage_q  <= stage_d;
			step_q   <= step_d;
			ld_q     <= ld_d;
			first_q  <= first_d;
			stop_q   <= stop_d;
			paper_q  <= paper_d;
			lines_q  <= lines_d;
			pins_q   <= pins_d;
			men_q    <= men_d;
			hen_q    <= hen_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take)
				skid_valid_q <= 1'b0;
		end else if (fire) begin
			if (!out_valid_q || out_take)
				out_valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take)
				out_q <= skid_q;
		end else if (fire) begin
			if (!out_valid_q || out_take)
				out_q <= res_d;
			else
				skid_q <= res_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign motor_pins    = out_q.motor_pins;
	assign strobe_first  = out_q.strobe_first;
	assign strobe_second = out_q.strobe_second;
	assign latch_line    = out_q.latch_line;
	assign motor_running = out_q.motor_running;
	assign heat_running  = out_q.heat_running;
	assign busy_res      = out_q.busy_res;
	assign end_cause     = out_q.end_cause;

	`TPLS_ASSERT_IMP(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full with empty output")
	`TPLS_ASSERT_IMP(a_strobe_excl, out_valid_q, !(strobe_first && strobe_second), "two strobes")
	`TPLS_ASSERT_IMP(a_end_idle, out_valid_q && end_cause != tpls_pkg::CAUSE_NONE, !busy_res, "busy")
	`TPLS_ASSERT_IMP(a_pins_motor, out_valid_q, (motor_pins != 4'd0) == motor_running, "pins vs motor")
	`TPLS_ASSERT_IMP(a_heat_in_job, out_valid_q && heat_running, busy_res, "heat outside job")

endmodule

`default_nettype wire
